[hw/rtl/gce_pkg.sv]
// Shared constants, types and a helper function for the GPRMC coordinate extractor.
`default_nettype none

package gce_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [2:0] HDR_DONE       = 3'd6;
    localparam logic [2:0] VALIDATE_READY = 3'd2;
    localparam logic [2:0] FIELD_LAT      = 3'd3;
    localparam logic [2:0] FIELD_LON      = 3'd5;
    localparam logic [2:0] FIELD_END      = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       wr_lat;
        logic       wr_lon;
        logic       clr_stores;
        logic       clr_fills;
        logic       burst_run;
    } t_cmd;

    typedef struct packed {
        logic burst_end;
    } t_sts;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_DOLLAR;
            3'd1:    ch = CH_G;
            3'd2:    ch = CH_P;
            3'd3:    ch = CH_R;
            3'd4:    ch = CH_M;
            3'd5:    ch = CH_C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/gprmc_coordinate_extractor_core.sv]
// Top level of the GPRMC coordinate extractor.
// The block takes one received byte per cycle while it parses a sentence. The comma that closes
// the sixth field starts a read-out of 2*COORD_SIZE beats, latitude slots first and then
// longitude slots, one store slot per cycle while the output is not stalled, through a single
// output register; the input stays stalled until the last slot has been loaded into it.
`default_nettype none

module gprmc_coordinate_extractor_core #(
    parameter int COORD_SIZE = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_coord_select,
    output logic [7:0]      o_coord_char,
    output logic            o_last_char
);
    import gce_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    gce_dpath #(
        .COORD_SIZE (COORD_SIZE)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_out_stall    (i_out_stall),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .o_coord_select (o_coord_select),
        .o_coord_char   (o_coord_char),
        .o_last_char    (o_last_char)
    );

endmodule

`default_nettype wire

[hw/rtl/gce_ctrl.sv]
// Controller: header matching, comma counting and the parse/burst state machine.
`default_nettype none

module gce_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [7:0]    i_rx_byte,
    input  wire gce_pkg::t_sts i_sts,
    output gce_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);
    import gce_pkg::*;

    localparam logic ST_PARSE = 1'b0;
    localparam logic ST_BURST = 1'b1;

    logic       r_state, n_state;
    logic [2:0] r_hdr, n_hdr;
    logic [2:0] r_comma, n_comma;
    logic [2:0] comma_inc;
    logic       take;

    assign take       = i_in_valid && (r_state == ST_PARSE);
    assign comma_inc  = r_comma + 3'd1;
    assign o_in_stall = (r_state == ST_BURST);

    always_comb begin
        n_state         = r_state;
        n_hdr           = r_hdr;
        n_comma         = r_comma;
        o_cmd           = '0;
        o_cmd.data      = i_rx_byte;
        o_cmd.burst_run = (r_state == ST_BURST);
        case (r_state)
            ST_PARSE: begin
                if (take) begin
                    if (r_hdr < HDR_DONE) begin
                        if (i_rx_byte == hdr_char(r_hdr)) begin
                            n_hdr = r_hdr + 3'd1;
                        end else begin
                            n_hdr = 3'd0;
                        end
                    end else if (i_rx_byte == CH_COMMA) begin
                        if (comma_inc == FIELD_END) begin
                            n_hdr           = 3'd0;
                            n_comma         = 3'd0;
                            o_cmd.clr_fills = 1'b1;
                            n_state         = ST_BURST;
                        end else begin
                            n_comma = comma_inc;
                        end
                    end else if (r_comma == VALIDATE_READY) begin
                        if (i_rx_byte == CH_A) begin
                            o_cmd.clr_stores = 1'b1;
                            o_cmd.clr_fills  = 1'b1;
                        end else begin
                            n_hdr   = 3'd0;
                            n_comma = 3'd0;
                        end
                    end else if (r_comma inside {[FIELD_LAT:FIELD_LON - 3'd1]}) begin
                        o_cmd.wr_lat = 1'b1;
                    end else if (r_comma inside {[FIELD_LON:FIELD_END - 3'd1]}) begin
                        o_cmd.wr_lon = 1'b1;
                    end
                end
            end
            ST_BURST: begin
                if (i_sts.burst_end) begin
                    n_state = ST_PARSE;
                end
            end
            default: begin
                n_state = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PARSE;
            r_hdr   <= 3'd0;
            r_comma <= 3'd0;
        end else begin
            r_state <= n_state;
            r_hdr   <= n_hdr;
            r_comma <= n_comma;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gce_dpath.sv]
// Datapath: latitude and longitude stores, fill counters, burst read-out and output register.
`default_nettype none

module gce_dpath #(
    parameter int COORD_SIZE = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gce_pkg::t_cmd i_cmd,
    input  wire logic          i_out_stall,
    output gce_pkg::t_sts      o_sts,
    output logic               o_out_valid,
    output logic               o_coord_select,
    output logic [7:0]         o_coord_char,
    output logic               o_last_char
);
    import gce_pkg::*;

    localparam int IW = $clog2(COORD_SIZE);
    localparam logic [IW-1:0] IDX_LAST = IW'(COORD_SIZE - 1);

    logic [7:0]    r_lat [COORD_SIZE];
    logic [7:0]    r_lon [COORD_SIZE];
    logic [IW-1:0] r_lat_fill;
    logic [IW-1:0] r_lon_fill;
    logic [IW-1:0] r_idx;
    logic          r_sel;
    logic          r_out_valid;
    logic          r_out_sel;
    logic [7:0]    r_out_char;
    logic          r_out_last;

    logic load;
    logic at_last;

    assign load    = i_cmd.burst_run && (!r_out_valid || !i_out_stall);
    assign at_last = r_sel && (r_idx == IDX_LAST);

    assign o_sts.burst_end = load && at_last;

    assign o_out_valid    = r_out_valid;
    assign o_coord_select = r_out_sel;
    assign o_coord_char   = r_out_char;
    assign o_last_char    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_stores) begin
            for (int i = 0; i < COORD_SIZE; i++) begin
                r_lat[i] <= 8'h00;
                r_lon[i] <= 8'h00;
            end
        end else if (i_cmd.wr_lat) begin
            if (r_lat_fill < IDX_LAST) begin
                r_lat[r_lat_fill] <= i_cmd.data;
            end else begin
                r_lat[IDX_LAST] <= 8'h00;
            end
        end else if (i_cmd.wr_lon) begin
            if (r_lon_fill < IDX_LAST) begin
                r_lon[r_lon_fill] <= i_cmd.data;
            end else begin
                r_lon[IDX_LAST] <= 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_fill <= '0;
            r_lon_fill <= '0;
        end else if (i_cmd.clr_fills) begin
            r_lat_fill <= '0;
            r_lon_fill <= '0;
        end else begin
            if (i_cmd.wr_lat && (r_lat_fill < IDX_LAST)) begin
                r_lat_fill <= r_lat_fill + 1'b1;
            end
            if (i_cmd.wr_lon && (r_lon_fill < IDX_LAST)) begin
                r_lon_fill <= r_lon_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
            if (at_last) begin
                r_idx <= '0;
                r_sel <= 1'b0;
            end else if (r_idx == IDX_LAST) begin
                r_idx <= '0;
                r_sel <= 1'b1;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_sel  <= r_sel;
            r_out_char <= r_sel ? r_lon[r_idx] : r_lat[r_idx];
            r_out_last <= at_last;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gce_checker.sv]
// Port-level checks for the GPRMC coordinate extractor, bound to the top level.
`default_nettype none

module gce_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [7:0] i_rx_byte,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_coord_select,
    input wire logic [7:0] o_coord_char,
    input wire logic       o_last_char
);
    import gce_pkg::*;

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_coord_select)
            && $stable(o_coord_char) && $stable(o_last_char))
        else $error("A stalled output beat changed.");

    a_burst_starts_on_comma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid) && ($past(i_rx_byte) == CH_COMMA))
        else $error("The read-out began without an accepted comma.");

    a_input_held_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_char |-> o_in_stall)
        else $error("Input was open while a read-out was unfinished.");

    a_last_is_longitude: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_char |-> o_coord_select)
        else $error("The final beat did not come from the longitude store.");

endmodule

bind gprmc_coordinate_extractor_core gce_checker u_gce_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_rx_byte      (i_rx_byte),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_coord_select (o_coord_select),
    .o_coord_char   (o_coord_char),
    .o_last_char    (o_last_char)
);

`default_nettype wire
